// ===== src/hre_pkg.sv =====
`timescale 1ns / 1ps

package hre_pkg;

   // Record limits
   localparam int unsigned MAX_RECORD_BYTES = 32;
   localparam int unsigned JOB_BYTES        = 8;   // byte slots per job (7 used at most)
   localparam int unsigned QUEUE_DEPTH      = 2;

   // Request opcodes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_DATA  = 2'd1;
   localparam logic [1:0] OP_SEG   = 2'd2;
   localparam logic [1:0] OP_END   = 2'd3;

   // Record type bytes
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_END  = 8'h01;
   localparam logic [7:0] REC_SEG  = 8'h02;

   // ASCII codes
   localparam logic [6:0] CH_NL    = 7'h0A;
   localparam logic [6:0] CH_COLON = 7'h3A;
   localparam logic [6:0] CH_L     = 7'h4C;
   localparam logic [6:0] CH_S     = 7'h53;

   // One queued job: optional "LS", optional newline + ':', a run of bytes
   // printed as hex pairs, optional trailing newline.
   typedef struct packed {
      logic                          ls;
      logic                          lead;
      logic                          tail;
      logic [2:0]                    nbytes;
      logic [JOB_BYTES-1:0][7:0]     bytes;
   } job_type;

   typedef enum logic [6:0] {
      ST_L     = 7'b0000001,
      ST_S     = 7'b0000010,
      ST_NL    = 7'b0000100,
      ST_COLON = 7'b0001000,
      ST_HI    = 7'b0010000,
      ST_LO    = 7'b0100000,
      ST_TAIL  = 7'b1000000
   } state_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = 7'h30 + {3'd0, nib};
      end else begin
         c = 7'h37 + {3'd0, nib};
      end
      return c;
   endfunction

endpackage

// ===== src/hre_front.sv =====
`timescale 1ns / 1ps

// Accepts requests, tracks record state and builds print jobs.
module hre_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [15:0]          csr_write_data,
   input  logic                 accept,
   input  logic [1:0]           opcode,
   input  logic [5:0]           byte_count,
   input  logic [15:0]          load_address,
   input  logic [7:0]           data_byte,
   input  logic [15:0]          segment_number,
   output logic                 push,
   output hre_pkg::job_type     job
);

   localparam logic [5:0] MAX_CNT = 6'(hre_pkg::MAX_RECORD_BYTES);

   logic [15:0] disp_ff;
   logic [7:0]  sum_ff, sum_in;
   logic [5:0]  remain_ff, remain_in;
   logic        open_ff, open_in;
   logic        first_seg_ff, first_seg_in;

   logic [5:0]  cnt;
   logic [15:0] addr;
   logic [7:0]  hsum, dsum, ssum;
   logic [5:0]  rem_dec;

   always_comb begin
      cnt     = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;
      addr    = load_address + disp_ff;
      hsum    = {2'd0, cnt} + addr[15:8] + addr[7:0];
      dsum    = sum_ff + data_byte;
      ssum    = 8'd4 + segment_number[15:8] + segment_number[7:0];
      rem_dec = remain_ff - 6'd1;

      sum_in       = sum_ff;
      remain_in    = remain_ff;
      open_in      = open_ff;
      first_seg_in = first_seg_ff;
      push         = 1'b0;
      job          = '0;

      if (accept) begin
         case (opcode)
            hre_pkg::OP_START: begin
               push         = 1'b1;
               job.lead     = 1'b1;
               job.bytes[0] = {2'd0, cnt};
               job.bytes[1] = addr[15:8];
               job.bytes[2] = addr[7:0];
               job.bytes[3] = hre_pkg::REC_DATA;
               job.bytes[4] = 8'd0 - hsum;
               job.nbytes   = (cnt == 6'd0) ? 3'd5 : 3'd4;
               remain_in    = cnt;
               open_in      = (cnt != 6'd0);
               sum_in       = (cnt == 6'd0) ? 8'd0 : hsum;
            end
            hre_pkg::OP_DATA: begin
               if (open_ff && remain_ff != 6'd0) begin
                  push         = 1'b1;
                  job.bytes[0] = data_byte;
                  job.bytes[1] = 8'd0 - dsum;
                  job.nbytes   = (rem_dec == 6'd0) ? 3'd2 : 3'd1;
                  remain_in    = rem_dec;
                  open_in      = (rem_dec != 6'd0);
                  sum_in       = (rem_dec == 6'd0) ? 8'd0 : dsum;
               end
            end
            hre_pkg::OP_SEG: begin
               push         = 1'b1;
               job.ls       = first_seg_ff;
               job.lead     = 1'b1;
               job.bytes[0] = 8'h02;
               job.bytes[1] = 8'h00;
               job.bytes[2] = 8'h00;
               job.bytes[3] = hre_pkg::REC_SEG;
               job.bytes[4] = segment_number[15:8];
               job.bytes[5] = segment_number[7:0];
               job.bytes[6] = 8'd0 - ssum;
               job.nbytes   = 3'd7;
               first_seg_in = 1'b0;
               open_in      = 1'b0;
               remain_in    = 6'd0;
               sum_in       = 8'd0;
            end
            default: begin
               push         = 1'b1;
               job.lead     = 1'b1;
               job.tail     = 1'b1;
               job.bytes[0] = 8'h00;
               job.bytes[1] = 8'h00;
               job.bytes[2] = 8'h00;
               job.bytes[3] = hre_pkg::REC_END;
               job.bytes[4] = 8'hFF;
               job.nbytes   = 3'd5;
               open_in      = 1'b0;
               remain_in    = 6'd0;
               sum_in       = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff      <= '0;
         sum_ff       <= '0;
         remain_ff    <= '0;
         open_ff      <= 1'b0;
         first_seg_ff <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            disp_ff <= csr_write_data;
         end
         sum_ff       <= sum_in;
         remain_ff    <= remain_in;
         open_ff      <= open_in;
         first_seg_ff <= first_seg_in;
      end
   end

endmodule

// ===== src/hre_queue.sv =====
`timescale 1ns / 1ps

// Short job queue between front and back.
module hre_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hre_pkg::job_type     push_job,
   input  logic                 pop,
   output hre_pkg::job_type     head_job,
   output logic                 not_empty,
   output logic                 full
);

   localparam int unsigned AW = $clog2(hre_pkg::QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(hre_pkg::QUEUE_DEPTH + 1);

   hre_pkg::job_type slot_ff [hre_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      not_empty = (cnt_ff != '0);
      full      = (cnt_ff == CW'(hre_pkg::QUEUE_DEPTH));
      head_job  = slot_ff[rd_ff];
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(hre_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(hre_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/hre_back.sv =====
`timescale 1ns / 1ps

// Prints jobs one character per cycle into the output register while rsp_stall is low.
module hre_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hre_pkg::job_type     head_job,
   input  logic                 not_empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [6:0]           rsp_character,
   output logic                 rsp_last_of_run
);

   hre_pkg::job_type   job_ff, job_in, cur_job;
   hre_pkg::state_type state_ff, state_in, cur_state, init_state;
   logic [2:0] idx_ff, idx_in, cur_idx;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;

   logic       emit, done, last_byte;
   logic [7:0] cur_byte;
   logic [6:0] ch;

   always_comb begin
      cur_job = busy_ff ? job_ff : head_job;
      if (cur_job.ls) begin
         init_state = hre_pkg::ST_L;
      end else if (cur_job.lead) begin
         init_state = hre_pkg::ST_NL;
      end else begin
         init_state = hre_pkg::ST_HI;
      end
      cur_state = busy_ff ? state_ff : init_state;
      cur_idx   = busy_ff ? idx_ff : 3'd0;
      cur_byte  = cur_job.bytes[cur_idx];
      last_byte = (cur_idx == cur_job.nbytes - 3'd1);

      emit = (busy_ff || not_empty) && (!valid_ff || !rsp_stall);
      pop  = emit && !busy_ff;

      ch       = hre_pkg::CH_NL;
      done     = 1'b0;
      state_in = state_ff;
      idx_in   = cur_idx;
      case (cur_state)
         hre_pkg::ST_L: begin
            ch       = hre_pkg::CH_L;
            state_in = hre_pkg::ST_S;
         end
         hre_pkg::ST_S: begin
            ch       = hre_pkg::CH_S;
            state_in = hre_pkg::ST_NL;
         end
         hre_pkg::ST_NL: begin
            ch       = hre_pkg::CH_NL;
            state_in = hre_pkg::ST_COLON;
         end
         hre_pkg::ST_COLON: begin
            ch       = hre_pkg::CH_COLON;
            state_in = hre_pkg::ST_HI;
         end
         hre_pkg::ST_HI: begin
            ch       = hre_pkg::hex_char(cur_byte[7:4]);
            state_in = hre_pkg::ST_LO;
         end
         hre_pkg::ST_LO: begin
            ch = hre_pkg::hex_char(cur_byte[3:0]);
            if (!last_byte) begin
               state_in = hre_pkg::ST_HI;
               idx_in   = cur_idx + 3'd1;
            end else if (cur_job.tail) begin
               state_in = hre_pkg::ST_TAIL;
            end else begin
               done = 1'b1;
            end
         end
         hre_pkg::ST_TAIL: begin
            ch   = hre_pkg::CH_NL;
            done = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase

      busy_in  = busy_ff;
      job_in   = job_ff;
      valid_in = valid_ff && rsp_stall;
      char_in  = char_ff;
      last_in  = last_ff;
      if (emit) begin
         busy_in  = !done;
         valid_in = 1'b1;
         char_in  = ch;
         last_in  = done;
      end
      if (pop) begin
         job_in = head_job;
      end
      if (!emit) begin
         state_in = state_ff;
         idx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      char_ff <= char_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         state_ff <= hre_pkg::ST_NL;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         state_ff <= state_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_character   = char_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== src/hex_record_encoder_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall     opcode, byte_count, load_address,
//                                                data_byte, segment_number
// rsp_      out        rsp_valid / rsp_stall     character, last_of_run
// csr_      in         csr_write_enable          csr_write_data (load displacement)
//
// One character leaves per cycle while rsp_stall is low; the back-end printer sets the pace.
// A data byte request prints its byte in hex, and the checksum too when it closes
// the record; each header, segment and end record prints newline, ':' and hex.
// Requests are taken every cycle while the 2-entry job queue has room.
// Synchronous active-high reset; no clearing pass, ready the cycle after.
// rsp_stall holds the output register; the queue keeps req_ flowing meanwhile until it fills.
module hex_record_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_byte_count,
   input  logic [15:0] req_load_address,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_segment_number,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_character,
   output logic        rsp_last_of_run
);

   logic             accept;
   logic             push, pop, not_empty, full;
   hre_pkg::job_type push_job, head_job;

   // stall only on a full queue, so the front never waits on the printer directly
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   // front: classifies each request, keeps checksum and record state
   hre_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .opcode           (req_opcode),
      .byte_count       (req_byte_count),
      .load_address     (req_load_address),
      .data_byte        (req_data_byte),
      .segment_number   (req_segment_number),
      .push             (push),
      .job              (push_job)
   );

   // decoupling queue
   hre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .full      (full)
   );

   // back: walks each job out as characters
   hre_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .not_empty       (not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== src/hre_checker.sv =====
`timescale 1ns / 1ps

module hre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_character,
   input logic        rsp_last_of_run
);

   // a stalled request stays on offer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request withdrawn");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character)
                                 && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // only hex digits, newline, ':', 'L', 'S' are ever printed
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_character >= 7'h30 && rsp_character <= 7'h39)
                     || (rsp_character >= 7'h41 && rsp_character <= 7'h46)
                     || rsp_character == 7'h0A || rsp_character == 7'h3A
                     || rsp_character == 7'h4C || rsp_character == 7'h53))
      else $error("unexpected character");

   // a colon or an 'L' never ends a request's output
   a_no_early_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == 7'h3A || rsp_character == 7'h4C)
         |-> !rsp_last_of_run)
      else $error("run ended on colon or L");

   // 'S' follows a taken 'L' straight away
   a_ls_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_character == 7'h4C
         |=> rsp_valid && rsp_character == 7'h53)
      else $error("L not followed by S");

endmodule

bind hex_record_encoder_unit hre_checker u_hre_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_character   (rsp_character),
   .rsp_last_of_run (rsp_last_of_run)
);
